// File: rtl/triangle_tess_pattern_gen_assert.svh
// Assertion macros for the tessellation pattern generator back end.
// Each macro expects clk and rst_n in scope.
`ifndef TRIANGLE_TESS_PATTERN_GEN_ASSERT_SVH
`define TRIANGLE_TESS_PATTERN_GEN_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TTPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttpg assertion failed");

// Next-cycle implication, checked outside reset
`define TTPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttpg assertion failed");

`endif

// File: rtl/ttpg_pkg.sv
package ttpg_pkg;

    localparam int MAX_LEVEL       = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int ROW_W           = 6;
    localparam int LEVEL_W         = 6;
    localparam int IDX_W           = 10;
    localparam int COORD_W         = COORD_FRAC_BITS + 1;
    localparam int REM_W           = 5;
    localparam int CNT_W           = 7;
    localparam int COORD_ONE       = 1 << COORD_FRAC_BITS;
    localparam logic [LEVEL_W-1:0] RESET_LEVEL = LEVEL_W'(5);

    // Per-level step of one coordinate unit: 2^F / N as quotient and remainder
    typedef struct packed {
        logic [LEVEL_W-1:0] n;
        logic [COORD_W-1:0] q0;
        logic [REM_W-1:0]   r0;
    } coef_t;

    // Exact fixed point value kept as quotient plus remainder
    typedef struct packed {
        logic [COORD_W-1:0] q;
        logic [REM_W-1:0]   rem;
    } acc_t;

    // One classified row request handed from front to back
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             err;
        logic [IDX_W-1:0] cur;
        acc_t             u;
    } job_t;

    // Entry 0 stands for a level of one
    localparam logic [COORD_W-1:0] RECIP_Q [0:MAX_LEVEL] = '{
        COORD_W'(COORD_ONE / 1),  COORD_W'(COORD_ONE / 1),  COORD_W'(COORD_ONE / 2),
        COORD_W'(COORD_ONE / 3),  COORD_W'(COORD_ONE / 4),  COORD_W'(COORD_ONE / 5),
        COORD_W'(COORD_ONE / 6),  COORD_W'(COORD_ONE / 7),  COORD_W'(COORD_ONE / 8),
        COORD_W'(COORD_ONE / 9),  COORD_W'(COORD_ONE / 10), COORD_W'(COORD_ONE / 11),
        COORD_W'(COORD_ONE / 12), COORD_W'(COORD_ONE / 13), COORD_W'(COORD_ONE / 14),
        COORD_W'(COORD_ONE / 15), COORD_W'(COORD_ONE / 16), COORD_W'(COORD_ONE / 17),
        COORD_W'(COORD_ONE / 18), COORD_W'(COORD_ONE / 19), COORD_W'(COORD_ONE / 20),
        COORD_W'(COORD_ONE / 21), COORD_W'(COORD_ONE / 22), COORD_W'(COORD_ONE / 23),
        COORD_W'(COORD_ONE / 24), COORD_W'(COORD_ONE / 25), COORD_W'(COORD_ONE / 26),
        COORD_W'(COORD_ONE / 27), COORD_W'(COORD_ONE / 28), COORD_W'(COORD_ONE / 29),
        COORD_W'(COORD_ONE / 30), COORD_W'(COORD_ONE / 31), COORD_W'(COORD_ONE / 32)
    };

    localparam logic [REM_W-1:0] RECIP_R [0:MAX_LEVEL] = '{
        REM_W'(COORD_ONE % 1),  REM_W'(COORD_ONE % 1),  REM_W'(COORD_ONE % 2),
        REM_W'(COORD_ONE % 3),  REM_W'(COORD_ONE % 4),  REM_W'(COORD_ONE % 5),
        REM_W'(COORD_ONE % 6),  REM_W'(COORD_ONE % 7),  REM_W'(COORD_ONE % 8),
        REM_W'(COORD_ONE % 9),  REM_W'(COORD_ONE % 10), REM_W'(COORD_ONE % 11),
        REM_W'(COORD_ONE % 12), REM_W'(COORD_ONE % 13), REM_W'(COORD_ONE % 14),
        REM_W'(COORD_ONE % 15), REM_W'(COORD_ONE % 16), REM_W'(COORD_ONE % 17),
        REM_W'(COORD_ONE % 18), REM_W'(COORD_ONE % 19), REM_W'(COORD_ONE % 20),
        REM_W'(COORD_ONE % 21), REM_W'(COORD_ONE % 22), REM_W'(COORD_ONE % 23),
        REM_W'(COORD_ONE % 24), REM_W'(COORD_ONE % 25), REM_W'(COORD_ONE % 26),
        REM_W'(COORD_ONE % 27), REM_W'(COORD_ONE % 28), REM_W'(COORD_ONE % 29),
        REM_W'(COORD_ONE % 30), REM_W'(COORD_ONE % 31), REM_W'(COORD_ONE % 32)
    };

    // Add one unit 2^F/N to an exact quotient/remainder pair
    function automatic acc_t acc_up(acc_t a, coef_t c);
        logic [LEVEL_W-1:0] sum;
        acc_t               res;
        sum = {1'b0, a.rem} + {1'b0, c.r0};
        if (sum >= c.n)
        begin
            res.rem = REM_W'(sum - c.n);
            res.q   = a.q + c.q0 + COORD_W'(1);
        end
        else
        begin
            res.rem = REM_W'(sum);
            res.q   = a.q + c.q0;
        end
        return res;
    endfunction

    // Take one unit 2^F/N off an exact quotient/remainder pair
    function automatic acc_t acc_down(acc_t a, coef_t c);
        logic [LEVEL_W-1:0] diff;
        acc_t               res;
        diff = {1'b0, a.rem} + c.n - {1'b0, c.r0};
        if (a.rem >= c.r0)
        begin
            res.rem = a.rem - c.r0;
            res.q   = a.q - c.q0;
        end
        else
        begin
            res.rem = REM_W'(diff);
            res.q   = a.q - c.q0 - COORD_W'(1);
        end
        return res;
    endfunction

endpackage

// File: rtl/ttpg_front.sv
module ttpg_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [ttpg_pkg::ROW_W-1:0] row,
    input  ttpg_pkg::coef_t           coef,
    output logic                      push,
    output ttpg_pkg::job_t            push_data,
    input  logic                      full
);
    import ttpg_pkg::*;

    typedef enum logic {
        F_IDLE,
        F_RUN
    } fstate_t;

    fstate_t          state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             err_reg, err_next;
    logic [ROW_W-1:0] cnt_reg, cnt_next;
    acc_t             acc_reg, acc_next;
    logic [11:0]      tri_num;

    assign in_stall = (state_reg != F_IDLE);

    // Start index of the row: r(r+1)/2
    assign tri_num = 12'(row_reg) * 12'({1'b0, row_reg} + 7'd1);

    assign push_data.row = row_reg;
    assign push_data.err = err_reg;
    assign push_data.cur = IDX_W'(tri_num >> 1);
    assign push_data.u   = acc_reg;

    // Classify the row, then walk u up to r/N one unit per cycle unless it is out of range
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    row_next   = row;
                    err_next   = (row > coef.n);
                    cnt_next   = row;
                    acc_next   = '0;
                    state_next = F_RUN;
                end
            end
            F_RUN:
            begin
                if (err_reg || (cnt_reg == '0))
                begin
                    if (!full)
                    begin
                        push       = 1'b1;
                        state_next = F_IDLE;
                    end
                end
                else
                begin
                    acc_next = acc_up(acc_reg, coef);
                    cnt_next = cnt_reg - ROW_W'(1);
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            row_reg   <= '0;
            err_reg   <= 1'b0;
            cnt_reg   <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            err_reg   <= err_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// File: rtl/ttpg_queue.sv
module ttpg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ttpg_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output ttpg_pkg::job_t pop_data,
    output logic           empty
);
    import ttpg_pkg::*;

    job_t       mem_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/ttpg_back.sv
module ttpg_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ttpg_pkg::coef_t             coef,
    input  logic                        empty,
    input  ttpg_pkg::job_t              pop_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        tri_valid,
    output logic [ttpg_pkg::IDX_W-1:0]  tri_first,
    output logic [ttpg_pkg::IDX_W-1:0]  tri_second,
    output logic [ttpg_pkg::IDX_W-1:0]  tri_third,
    output logic                        vert_valid,
    output logic [ttpg_pkg::IDX_W-1:0]  vert_index,
    output logic [ttpg_pkg::COORD_W-1:0] coord_u,
    output logic [ttpg_pkg::COORD_W-1:0] coord_v,
    output logic                        row_error,
    output logic                        last
);
    import ttpg_pkg::*;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } bstate_t;

    bstate_t          state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             err_reg, err_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [ROW_W-1:0] k_reg, k_next;
    acc_t             u_reg, u_next;
    acc_t             v_reg, v_next;

    logic                out_valid_reg, out_valid_next;
    logic                tri_valid_reg, tri_valid_next;
    logic [IDX_W-1:0]    tri_first_reg, tri_first_next;
    logic [IDX_W-1:0]    tri_second_reg, tri_second_next;
    logic [IDX_W-1:0]    tri_third_reg, tri_third_next;
    logic                vert_valid_reg, vert_valid_next;
    logic [IDX_W-1:0]    vert_index_reg, vert_index_next;
    logic [COORD_W-1:0]  coord_u_reg, coord_u_next;
    logic [COORD_W-1:0]  coord_v_reg, coord_v_next;
    logic                row_error_reg, row_error_next;
    logic                last_reg, last_next;

    logic [CNT_W-1:0] ntris, nverts, count_m1;
    logic [IDX_W-1:0] prev, jx;
    logic             is_tri, is_vert, is_last, out_free;

    // Result counts of the current row
    assign ntris    = (row_reg != '0) ? (CNT_W'({row_reg, 1'b0}) - CNT_W'(1)) : '0;
    assign nverts   = CNT_W'(row_reg) + CNT_W'(1);
    assign count_m1 = ((nverts > ntris) ? nverts : ntris) - CNT_W'(1);
    assign prev     = cur_reg - IDX_W'(row_reg);
    assign jx       = IDX_W'(k_reg >> 1);
    assign is_tri   = (CNT_W'(k_reg) < ntris);
    assign is_vert  = (k_reg <= row_reg);
    assign is_last  = err_reg || (CNT_W'(k_reg) == count_m1);
    assign out_free = !out_valid_reg || !out_stall;

    // Sequence one result per free output slot
    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        err_next        = err_reg;
        cur_next        = cur_reg;
        k_next          = k_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        pop             = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        tri_valid_next  = tri_valid_reg;
        tri_first_next  = tri_first_reg;
        tri_second_next = tri_second_reg;
        tri_third_next  = tri_third_reg;
        vert_valid_next = vert_valid_reg;
        vert_index_next = vert_index_reg;
        coord_u_next    = coord_u_reg;
        coord_v_next    = coord_v_reg;
        row_error_next  = row_error_reg;
        last_next       = last_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    row_next   = pop_data.row;
                    err_next   = pop_data.err;
                    cur_next   = pop_data.cur;
                    u_next     = pop_data.u;
                    v_next     = '0;
                    k_next     = '0;
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    row_error_next  = err_reg;
                    last_next       = is_last;
                    tri_valid_next  = 1'b0;
                    tri_first_next  = '0;
                    tri_second_next = '0;
                    tri_third_next  = '0;
                    vert_valid_next = 1'b0;
                    vert_index_next = '0;
                    coord_u_next    = '0;
                    coord_v_next    = '0;
                    if (!err_reg && is_tri)
                    begin
                        tri_valid_next = 1'b1;
                        tri_first_next = prev + jx;
                        if (!k_reg[0])
                        begin
                            tri_second_next = cur_reg + jx;
                            tri_third_next  = cur_reg + jx + IDX_W'(1);
                        end
                        else
                        begin
                            tri_second_next = cur_reg + jx + IDX_W'(1);
                            tri_third_next  = prev + jx + IDX_W'(1);
                        end
                    end
                    if (!err_reg && is_vert)
                    begin
                        vert_valid_next = 1'b1;
                        vert_index_next = cur_reg + IDX_W'(k_reg);
                        coord_u_next    = u_reg.q;
                        coord_v_next    = v_reg.q;
                    end
                    // Step the coordinates only while vertices remain
                    if (k_reg < row_reg)
                    begin
                        u_next = acc_down(u_reg, coef);
                        v_next = acc_up(v_reg, coef);
                    end
                    k_next = k_reg + ROW_W'(1);
                    if (is_last)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            row_reg        <= '0;
            err_reg        <= 1'b0;
            cur_reg        <= '0;
            k_reg          <= '0;
            u_reg          <= '0;
            v_reg          <= '0;
            out_valid_reg  <= 1'b0;
            tri_valid_reg  <= 1'b0;
            tri_first_reg  <= '0;
            tri_second_reg <= '0;
            tri_third_reg  <= '0;
            vert_valid_reg <= 1'b0;
            vert_index_reg <= '0;
            coord_u_reg    <= '0;
            coord_v_reg    <= '0;
            row_error_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            err_reg        <= err_next;
            cur_reg        <= cur_next;
            k_reg          <= k_next;
            u_reg          <= u_next;
            v_reg          <= v_next;
            out_valid_reg  <= out_valid_next;
            tri_valid_reg  <= tri_valid_next;
            tri_first_reg  <= tri_first_next;
            tri_second_reg <= tri_second_next;
            tri_third_reg  <= tri_third_next;
            vert_valid_reg <= vert_valid_next;
            vert_index_reg <= vert_index_next;
            coord_u_reg    <= coord_u_next;
            coord_v_reg    <= coord_v_next;
            row_error_reg  <= row_error_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tri_valid  = tri_valid_reg;
    assign tri_first  = tri_first_reg;
    assign tri_second = tri_second_reg;
    assign tri_third  = tri_third_reg;
    assign vert_valid = vert_valid_reg;
    assign vert_index = vert_index_reg;
    assign coord_u    = coord_u_reg;
    assign coord_v    = coord_v_reg;
    assign row_error  = row_error_reg;
    assign last       = last_reg;

    `include "triangle_tess_pattern_gen_assert.svh"

    `TTPG_ASSERT_NOW(a_err_single, out_valid_reg && row_error_reg, last_reg && !tri_valid_reg && !vert_valid_reg)
    `TTPG_ASSERT_NOW(a_result_kind, out_valid_reg, tri_valid_reg || vert_valid_reg || row_error_reg)
    `TTPG_ASSERT_NOW(a_k_in_range, state_reg == B_RUN && !err_reg, CNT_W'(k_reg) <= count_m1)
    `TTPG_ASSERT_NEXT(a_pop_starts, pop, state_reg == B_RUN && k_reg == '0)

endmodule

// File: rtl/triangle_tess_pattern_gen.sv
// Uniform triangle tessellation pattern generator. Write the subdivision level N on
// cfg_wr_data with cfg_wr_en (reset 5; 0 is used as 1, above 32 as 32), then send row
// numbers r. Each row gives max(r+1, 2r-1) result beats, one per cycle while out_stall
// is low: beat k carries vertex k (index r(r+1)/2+k, u=(r-k)/N, v=k/N in Q1.16,
// truncated) and triangle k into the previous row, each with its own valid flag, and
// last marks the row's final beat. A row above N gives one beat with row_error set.
// The output sequencer sets the rate: it loads the next request from the two-entry
// queue only after the last beat of the current row. The front end takes a row, steps
// the u coordinate up to r/N (skipped for a row above N) and hands the row over once
// the queue has room, holding in_stall high until then. It is never slower than the
// sequencer for the same row, so it only adds latency ahead of the first beat and runs
// ahead while the sequencer drains earlier rows.
module triangle_tess_pattern_gen (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [ttpg_pkg::LEVEL_W-1:0] cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ttpg_pkg::ROW_W-1:0]   row,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         tri_valid,
    output logic [ttpg_pkg::IDX_W-1:0]   tri_first,
    output logic [ttpg_pkg::IDX_W-1:0]   tri_second,
    output logic [ttpg_pkg::IDX_W-1:0]   tri_third,
    output logic                         vert_valid,
    output logic [ttpg_pkg::IDX_W-1:0]   vert_index,
    output logic [ttpg_pkg::COORD_W-1:0] coord_u,
    output logic [ttpg_pkg::COORD_W-1:0] coord_v,
    output logic                         row_error,
    output logic                         last
);
    import ttpg_pkg::*;

    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] eff_level;
    coef_t              coef;
    logic               push, full, pop, empty;
    job_t               push_data, pop_data;

    // Hold the level register
    always_comb
    begin
        level_next = cfg_wr_en ? cfg_wr_data : level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= RESET_LEVEL;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    // Saturate the level and look up its per-unit step
    always_comb
    begin
        if (level_reg == '0)
        begin
            eff_level = LEVEL_W'(1);
        end
        else if (level_reg > LEVEL_W'(MAX_LEVEL))
        begin
            eff_level = LEVEL_W'(MAX_LEVEL);
        end
        else
        begin
            eff_level = level_reg;
        end
        coef.n  = eff_level;
        coef.q0 = RECIP_Q[eff_level];
        coef.r0 = RECIP_R[eff_level];
    end

    ttpg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .row       (row),
        .coef      (coef),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    ttpg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    ttpg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef),
        .empty      (empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tri_valid  (tri_valid),
        .tri_first  (tri_first),
        .tri_second (tri_second),
        .tri_third  (tri_third),
        .vert_valid (vert_valid),
        .vert_index (vert_index),
        .coord_u    (coord_u),
        .coord_v    (coord_v),
        .row_error  (row_error),
        .last       (last)
    );

endmodule
